### hdl/gbd_pkg.sv
// ----------------------------------------------------------------------------
// gbd_pkg - shared types for the grapheme boundary detector
// Break classes, Indic conjunct classes, tracker states and the item record
// that travels from the classify front end through the queue to the decide
// back end.
// ----------------------------------------------------------------------------
package gbd_pkg;

    // Grapheme break property of one code point
    typedef enum logic [3:0] {
        CLS_OTHER       = 4'd0,
        CLS_CR          = 4'd1,
        CLS_LF          = 4'd2,
        CLS_CONTROL     = 4'd3,
        CLS_EXTEND      = 4'd4,
        CLS_ZWJ         = 4'd5,
        CLS_RI          = 4'd6,
        CLS_PREPEND     = 4'd7,
        CLS_SPACINGMARK = 4'd8,
        CLS_L           = 4'd9,
        CLS_V           = 4'd10,
        CLS_T           = 4'd11,
        CLS_LV          = 4'd12,
        CLS_LVT         = 4'd13
    } t_break_class;

    // Indic conjunct break property
    typedef enum logic [1:0] {
        INCB_NONE      = 2'd0,
        INCB_CONSONANT = 2'd1,
        INCB_EXTEND    = 2'd2,
        INCB_LINKER    = 2'd3
    } t_incb;

    // Emoji ZWJ sequence tracker
    typedef enum logic [1:0] {
        EMO_NONE      = 2'd0,
        EMO_PICT      = 2'd1,
        EMO_AFTER_ZWJ = 2'd2
    } t_emo_state;

    // Indic conjunct tracker
    typedef enum logic [1:0] {
        CONJ_NONE      = 2'd0,
        CONJ_CONSONANT = 2'd1,
        CONJ_LINKED    = 2'd2
    } t_conj_state;

    // Classified code point
    typedef struct packed {
        logic         first;
        t_break_class cls;
        logic         pict;
        t_incb        incb;
    } t_cp_item;

    // Stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 8;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

endpackage

### hdl/grapheme_boundary_detector.sv
// ----------------------------------------------------------------------------
// grapheme_boundary_detector - grapheme cluster boundary marker
// Marks, per code point, whether a grapheme cluster starts there.
// ----------------------------------------------------------------------------
// Takes one code point's properties per transaction (break class,
// pictograph flag, Indic conjunct class, and a start-of-text flag
// in tuser) and returns one transaction carrying a single cluster-start bit.
// One item is accepted and one result delivered per clock in steady flow;
// the result is registered in the two-entry queue between the classify front
// end and the decision back end and then in the output register. The back end
// keeps the previous class, the regional indicator parity, the emoji ZWJ
// tracker and the conjunct tracker, and decides each code point
// combinationally. A start-of-text flag restarts the context.
// ----------------------------------------------------------------------------
module grapheme_boundary_detector (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [3:0] break_class, [4] pictograph, [6:5] conjunct_class, [7] zero
    input  logic [gbd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] first_of_text
    input  logic [gbd_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] cluster_start, [7:1] zero
    output logic [gbd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    gbd_pkg::t_cp_item w_front_item;
    gbd_pkg::t_cp_item w_queue_item;
    logic              w_front_valid;
    logic              w_queue_ready;
    logic              w_queue_valid;
    logic              w_pop;

    // Unpack and classify
    gbd_front u_front (
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_tdata      (s_axis_tdata),
        .i_tuser      (s_axis_tuser),
        .o_item_valid (w_front_valid),
        .i_item_ready (w_queue_ready),
        .o_item       (w_front_item)
    );

    // Decouple front from back
    gbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_item  (w_front_item),
        .o_ready (w_queue_ready),
        .i_pop   (w_pop),
        .o_valid (w_queue_valid),
        .o_item  (w_queue_item)
    );

    // Decide and track context
    gbd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_queue_valid),
        .i_item       (w_queue_item),
        .o_pop        (w_pop),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_tdata      (m_axis_tdata)
    );

endmodule

### hdl/gbd_front.sv
// ----------------------------------------------------------------------------
// gbd_front - input unpack and classify
// Splits the input transaction into its fields, folds the unused break
// class codes onto class other and hands a classified item to the queue.
// ----------------------------------------------------------------------------
module gbd_front (
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [gbd_pkg::IN_TDATA_W-1:0]   i_tdata,
    input  logic [gbd_pkg::IN_TUSER_W-1:0]   i_tuser,
    output logic                             o_item_valid,
    input  logic                             i_item_ready,
    output gbd_pkg::t_cp_item                o_item
);

    logic [3:0] w_raw_cls;

    assign w_raw_cls = i_tdata[3:0];

    // Classify: codes above LVT behave as class other
    always_comb begin
        o_item.first = i_tuser[0];
        if (w_raw_cls > 4'(gbd_pkg::CLS_LVT)) begin
            o_item.cls = gbd_pkg::CLS_OTHER;
        end else begin
            o_item.cls = gbd_pkg::t_break_class'(w_raw_cls);
        end
        o_item.pict = i_tdata[4];
        o_item.incb = gbd_pkg::t_incb'(i_tdata[6:5]);
    end

    // Pass the handshake to the queue
    assign o_item_valid = i_valid;
    assign o_ready      = i_item_ready;

endmodule

### hdl/gbd_queue.sv
// ----------------------------------------------------------------------------
// gbd_queue - short queue between front and back
// Register-based FIFO of classified items so the input and output sides
// stall independently.
// ----------------------------------------------------------------------------
module gbd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gbd_pkg::t_cp_item i_item,
    output logic              o_ready,
    input  logic              i_pop,
    output logic              o_valid,
    output gbd_pkg::t_cp_item o_item
);

    gbd_pkg::t_cp_item                r_mem [gbd_pkg::QUEUE_DEPTH];
    logic [gbd_pkg::QUEUE_PTR_W-1:0]  r_wr_ptr;
    logic [gbd_pkg::QUEUE_PTR_W-1:0]  r_rd_ptr;
    logic [gbd_pkg::QUEUE_CNT_W-1:0]  r_count;
    logic [gbd_pkg::QUEUE_PTR_W-1:0]  n_wr_ptr;
    logic [gbd_pkg::QUEUE_PTR_W-1:0]  n_rd_ptr;
    logic [gbd_pkg::QUEUE_CNT_W-1:0]  n_count;
    logic                             w_push;
    logic                             w_pop;

    assign o_ready = (r_count != gbd_pkg::QUEUE_CNT_W'(gbd_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    // Advance pointers with wrap and track fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            if (r_wr_ptr == gbd_pkg::QUEUE_PTR_W'(gbd_pkg::QUEUE_DEPTH - 1)) begin
                n_wr_ptr = '0;
            end else begin
                n_wr_ptr = r_wr_ptr + 1'b1;
            end
        end
        if (w_pop) begin
            if (r_rd_ptr == gbd_pkg::QUEUE_PTR_W'(gbd_pkg::QUEUE_DEPTH - 1)) begin
                n_rd_ptr = '0;
            end else begin
                n_rd_ptr = r_rd_ptr + 1'b1;
            end
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### hdl/gbd_back.sv
// ----------------------------------------------------------------------------
// gbd_back - boundary decision and context tracking
// Pops classified items, applies the boundary rule chain against the kept
// context (previous class, indicator run parity, emoji and conjunct
// trackers) and holds the result in the output register.
// ----------------------------------------------------------------------------
module gbd_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_item_valid,
    input  gbd_pkg::t_cp_item                i_item,
    output logic                             o_pop,
    output logic                             o_tvalid,
    input  logic                             i_tready,
    output logic [gbd_pkg::OUT_TDATA_W-1:0]  o_tdata
);

    gbd_pkg::t_break_class r_prev;
    logic                  r_ri_odd;
    gbd_pkg::t_emo_state   r_emo;
    gbd_pkg::t_conj_state  r_conj;
    logic                  r_out_valid;
    logic                  r_start;

    gbd_pkg::t_break_class n_prev;
    logic                  n_ri_odd;
    gbd_pkg::t_emo_state   n_emo;
    gbd_pkg::t_conj_state  n_conj;
    logic                  n_start;

    gbd_pkg::t_break_class w_prev;
    logic                  w_ri_odd;
    gbd_pkg::t_emo_state   w_emo;
    gbd_pkg::t_conj_state  w_conj;
    gbd_pkg::t_break_class w_cur;
    logic                  w_prev_ctl;
    logic                  w_cur_ctl;
    logic                  w_decide;

    // Take an item when the output register is free or being drained
    assign o_pop = i_item_valid && (!r_out_valid || i_tready);
    assign w_cur = i_item.cls;

    // Context seen by this item: restart at the first code point of a text
    always_comb begin
        if (i_item.first) begin
            w_prev   = gbd_pkg::CLS_OTHER;
            w_ri_odd = 1'b0;
            w_emo    = gbd_pkg::EMO_NONE;
            w_conj   = gbd_pkg::CONJ_NONE;
        end else begin
            w_prev   = r_prev;
            w_ri_odd = r_ri_odd;
            w_emo    = r_emo;
            w_conj   = r_conj;
        end
    end

    assign w_prev_ctl = (w_prev == gbd_pkg::CLS_CONTROL) || (w_prev == gbd_pkg::CLS_CR) ||
                        (w_prev == gbd_pkg::CLS_LF);
    assign w_cur_ctl  = (w_cur == gbd_pkg::CLS_CONTROL) || (w_cur == gbd_pkg::CLS_CR) ||
                        (w_cur == gbd_pkg::CLS_LF);

    // Rule chain in priority order, first match wins
    always_comb begin
        if (w_prev == gbd_pkg::CLS_CR && w_cur == gbd_pkg::CLS_LF) begin
            w_decide = 1'b0;
        end else if (w_prev_ctl || w_cur_ctl) begin
            w_decide = 1'b1;
        end else if (w_prev == gbd_pkg::CLS_L &&
                     (w_cur == gbd_pkg::CLS_L || w_cur == gbd_pkg::CLS_V ||
                      w_cur == gbd_pkg::CLS_LV || w_cur == gbd_pkg::CLS_LVT)) begin
            w_decide = 1'b0;
        end else if ((w_prev == gbd_pkg::CLS_LV || w_prev == gbd_pkg::CLS_V) &&
                     (w_cur == gbd_pkg::CLS_V || w_cur == gbd_pkg::CLS_T)) begin
            w_decide = 1'b0;
        end else if ((w_prev == gbd_pkg::CLS_LVT || w_prev == gbd_pkg::CLS_T) &&
                     w_cur == gbd_pkg::CLS_T) begin
            w_decide = 1'b0;
        end else if (w_cur == gbd_pkg::CLS_EXTEND || w_cur == gbd_pkg::CLS_ZWJ ||
                     w_cur == gbd_pkg::CLS_SPACINGMARK) begin
            w_decide = 1'b0;
        end else if (w_prev == gbd_pkg::CLS_PREPEND) begin
            w_decide = 1'b0;
        end else if (i_item.incb == gbd_pkg::INCB_CONSONANT &&
                     w_conj == gbd_pkg::CONJ_LINKED) begin
            w_decide = 1'b0;
        end else if (i_item.pict && w_prev == gbd_pkg::CLS_ZWJ &&
                     w_emo == gbd_pkg::EMO_AFTER_ZWJ) begin
            w_decide = 1'b0;
        end else if (w_prev == gbd_pkg::CLS_RI && w_cur == gbd_pkg::CLS_RI && w_ri_odd) begin
            w_decide = 1'b0;
        end else begin
            w_decide = 1'b1;
        end
    end

    // Next context and result
    always_comb begin
        n_start  = i_item.first || w_decide;
        n_prev   = w_cur;
        n_ri_odd = (w_cur == gbd_pkg::CLS_RI) ? !w_ri_odd : 1'b0;

        if (i_item.pict) begin
            n_emo = gbd_pkg::EMO_PICT;
        end else if (w_emo == gbd_pkg::EMO_PICT && w_cur == gbd_pkg::CLS_EXTEND) begin
            n_emo = gbd_pkg::EMO_PICT;
        end else if (w_emo == gbd_pkg::EMO_PICT && w_cur == gbd_pkg::CLS_ZWJ) begin
            n_emo = gbd_pkg::EMO_AFTER_ZWJ;
        end else begin
            n_emo = gbd_pkg::EMO_NONE;
        end

        case (i_item.incb)
            gbd_pkg::INCB_CONSONANT: n_conj = gbd_pkg::CONJ_CONSONANT;
            gbd_pkg::INCB_LINKER: begin
                n_conj = (w_conj != gbd_pkg::CONJ_NONE) ? gbd_pkg::CONJ_LINKED
                                                        : gbd_pkg::CONJ_NONE;
            end
            gbd_pkg::INCB_EXTEND: n_conj = w_conj;
            default:              n_conj = gbd_pkg::CONJ_NONE;
        endcase
    end

    // Context and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= gbd_pkg::CLS_OTHER;
            r_ri_odd    <= 1'b0;
            r_emo       <= gbd_pkg::EMO_NONE;
            r_conj      <= gbd_pkg::CONJ_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_prev   <= n_prev;
                r_ri_odd <= n_ri_odd;
                r_emo    <= n_emo;
                r_conj   <= n_conj;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_start <= n_start;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {(gbd_pkg::OUT_TDATA_W - 1)'(0), r_start};

    // A text always opens a cluster
    a_first_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.first) |=> r_start)
        else $error("first code point of a text did not start a cluster");

    // CR followed by LF never splits
    a_crlf_joined: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !i_item.first && r_prev == gbd_pkg::CLS_CR &&
         i_item.cls == gbd_pkg::CLS_LF) |=> !r_start)
        else $error("break between CR and LF");

    // A control code point always splits before it
    a_ctl_breaks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.cls == gbd_pkg::CLS_CONTROL) |=> r_start)
        else $error("no break before a control code point");

    // Odd indicator parity is only kept right after an indicator
    a_ri_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ri_odd |-> (r_prev == gbd_pkg::CLS_RI))
        else $error("indicator parity set after a non-indicator");

    // After-ZWJ emoji state is only kept right after a ZWJ
    a_emo_zwj: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_emo == gbd_pkg::EMO_AFTER_ZWJ) |-> (r_prev == gbd_pkg::CLS_ZWJ))
        else $error("emoji ZWJ state without a preceding ZWJ");

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb - testbench for grapheme_boundary_detector
// Streams code point properties into the detector and checks every returned
// cluster-start bit against a cycle-free model of the boundary rules. A short
// directed run covers each rule and the odd break classes; a random run mixes
// well-formed clusters (Hangul, emoji ZWJ chains, regional indicator runs,
// Indic conjuncts) with noise, under random idling on both sides and one long
// output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import gbd_pkg::*;

    localparam int RANDOM_ITEMS = 1450;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_AFTER   = 700;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    // Boundary model and queue of expected cluster-start bits
    class boundary_scoreboard;
        bit           expected_starts[$];
        t_break_class last_cls;
        bit           ri_run_odd;
        t_emo_state   emoji_seq;
        t_conj_state  conjunct;
        int           errors;

        function new();
            last_cls   = CLS_OTHER;
            ri_run_odd = 1'b0;
            emoji_seq  = EMO_NONE;
            conjunct   = CONJ_NONE;
            errors     = 0;
        endfunction

        function bit control_like(t_break_class c);
            return c == CLS_CONTROL || c == CLS_CR || c == CLS_LF;
        endfunction

        // Apply the rule chain from line-break rules down to the default break
        function bit boundary_rules(t_break_class prev, t_break_class cur, bit pict,
                                    t_incb incb, bit ri_odd, t_emo_state emo,
                                    t_conj_state conj);
            if (prev == CLS_CR && cur == CLS_LF) return 1'b0;
            if (control_like(prev) || control_like(cur)) return 1'b1;
            if (prev == CLS_L && (cur == CLS_L || cur == CLS_V ||
                                  cur == CLS_LV || cur == CLS_LVT)) return 1'b0;
            if ((prev == CLS_LV || prev == CLS_V) &&
                (cur == CLS_V || cur == CLS_T)) return 1'b0;
            if ((prev == CLS_LVT || prev == CLS_T) && cur == CLS_T) return 1'b0;
            if (cur == CLS_EXTEND || cur == CLS_ZWJ || cur == CLS_SPACINGMARK)
                return 1'b0;
            if (prev == CLS_PREPEND) return 1'b0;
            if (incb == INCB_CONSONANT && conj == CONJ_LINKED) return 1'b0;
            if (pict && prev == CLS_ZWJ && emo == EMO_AFTER_ZWJ) return 1'b0;
            if (prev == CLS_RI && cur == CLS_RI && ri_odd) return 1'b0;
            return 1'b1;
        endfunction

        // Note an accepted code point: predict its bit and advance the trackers
        function void note_code_point(bit first, logic [3:0] cls_raw, bit pict,
                                      t_incb incb);
            t_break_class cur;
            t_break_class prev;
            bit           ri_odd;
            t_emo_state   emo;
            t_conj_state  conj;
            bit           start;
            // classes past LVT act as other
            cur = (cls_raw > CLS_LVT) ? CLS_OTHER : t_break_class'(cls_raw);
            if (first) begin
                prev   = CLS_OTHER;
                ri_odd = 1'b0;
                emo    = EMO_NONE;
                conj   = CONJ_NONE;
                start  = 1'b1;
            end else begin
                prev   = last_cls;
                ri_odd = ri_run_odd;
                emo    = emoji_seq;
                conj   = conjunct;
                start  = boundary_rules(prev, cur, pict, incb, ri_odd, emo, conj);
            end
            expected_starts.push_back(start);

            ri_run_odd = (cur == CLS_RI) ? ~ri_odd : 1'b0;

            if (pict)
                emoji_seq = EMO_PICT;
            else if (emo == EMO_PICT && cur == CLS_EXTEND)
                emoji_seq = EMO_PICT;
            else if (emo == EMO_PICT && cur == CLS_ZWJ)
                emoji_seq = EMO_AFTER_ZWJ;
            else
                emoji_seq = EMO_NONE;

            if (incb == INCB_CONSONANT)
                conjunct = CONJ_CONSONANT;
            else if (conj != CONJ_NONE && incb == INCB_LINKER)
                conjunct = CONJ_LINKED;
            else if (conj != CONJ_NONE && incb == INCB_EXTEND)
                conjunct = conj;
            else
                conjunct = CONJ_NONE;

            last_cls = cur;
        endfunction

        // Compare one delivered bit with the oldest expectation
        function void check_result(bit got);
            bit want;
            if (expected_starts.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: unexpected result cluster_start=%0b", got);
                return;
            end
            want = expected_starts.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: cluster_start expected %0b actual %0b", want, got);
            end
        endfunction

        function int pending();
            return expected_starts.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;   // [3:0] break_class, [4] pict, [6:5] incb, [7] zero
    logic [0:0] s_axis_tuser = '0;   // [0] first_of_text
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;        // [0] cluster_start, [7:1] zero

    boundary_scoreboard sb = new();
    int  cp_sent = 0;
    int  starts_seen = 0;
    int  cycle_count = 0;
    bit  no_idle = 1'b0;
    bit  text_start = 1'b0;

    grapheme_boundary_detector DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Abort a hung run
    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Mostly short pauses, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Offer one code point and hold it until the transaction completes
    task automatic send_cp(bit first, logic [3:0] cls, bit pict, t_incb incb);
        int gap;
        gap = 0;
        if (cp_sent % 100 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
        if (!no_idle && $urandom_range(0, 99) >= 65)
            gap = idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid   <= 1'b1;
        s_axis_tdata    <= {1'b0, incb, pict, cls};
        s_axis_tuser[0] <= first;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_code_point(first, cls, pict, incb);
        cp_sent++;
    endtask

    // Send within a cluster; the text-start flag goes on the first item only
    task automatic put(logic [3:0] cls, bit pict, t_incb incb);
        send_cp(text_start, cls, pict, incb);
        text_start = 1'b0;
    endtask

    // Emit one random cluster, usually well formed, sometimes noise
    task automatic send_random_cluster();
        int    n;
        int    i;
        int    pick;
        t_incb ext_incb;
        text_start = ($urandom_range(0, 15) == 0);
        case ($urandom_range(0, 9))
            0, 1: begin
                // Hangul syllable: L* then V / LV / LVT, vowels and trailing T
                repeat ($urandom_range(0, 2)) put(CLS_L, 1'b0, INCB_NONE);
                pick = $urandom_range(0, 2);
                if (pick == 0) put(CLS_V, 1'b0, INCB_NONE);
                else if (pick == 1) put(CLS_LV, 1'b0, INCB_NONE);
                else put(CLS_LVT, 1'b0, INCB_NONE);
                if (pick != 2) repeat ($urandom_range(0, 2)) put(CLS_V, 1'b0, INCB_NONE);
                repeat ($urandom_range(0, 2)) put(CLS_T, 1'b0, INCB_NONE);
            end
            2: begin
                // Emoji ZWJ chain, occasionally broken off after the joiner
                put(CLS_OTHER, 1'b1, INCB_NONE);
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++) begin
                    repeat ($urandom_range(0, 2)) put(CLS_EXTEND, 1'b0, t_incb'($urandom_range(0, 3)));
                    put(CLS_ZWJ, 1'b0, t_incb'($urandom_range(0, 3)));
                    put(($urandom_range(0, 5) == 0) ? CLS_OTHER : CLS_OTHER,
                        ($urandom_range(0, 5) != 0), INCB_NONE);
                end
            end
            3: begin
                // Regional indicator run
                repeat ($urandom_range(1, 5)) put(CLS_RI, 1'b0, INCB_NONE);
            end
            4: begin
                // Indic conjunct: consonant, extends and linkers, consonant
                put(CLS_OTHER, 1'b0, INCB_CONSONANT);
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++) begin
                    ext_incb = ($urandom_range(0, 1) != 0) ? INCB_LINKER : INCB_EXTEND;
                    put(($urandom_range(0, 3) == 0) ? CLS_ZWJ : CLS_EXTEND, 1'b0, ext_incb);
                end
                put(CLS_OTHER, ($urandom_range(0, 7) == 0), INCB_CONSONANT);
            end
            5: begin
                // Line breaks and controls
                pick = $urandom_range(0, 2);
                if (pick == 0) begin
                    put(CLS_CR, 1'b0, INCB_NONE);
                    put(CLS_LF, 1'b0, INCB_NONE);
                end else if (pick == 1) begin
                    put(CLS_LF, 1'b0, INCB_NONE);
                end else begin
                    put(CLS_CONTROL, 1'b0, INCB_NONE);
                end
            end
            6: begin
                // Prepend before a base, or marks after it
                if ($urandom_range(0, 1) != 0) begin
                    repeat ($urandom_range(1, 2)) put(CLS_PREPEND, 1'b0, INCB_NONE);
                    put(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                        t_incb'($urandom_range(0, 3)));
                end else begin
                    put(CLS_OTHER, 1'b0, INCB_NONE);
                    repeat ($urandom_range(1, 2)) put(CLS_SPACINGMARK, 1'b0, INCB_NONE);
                end
            end
            default: begin
                // Noise: any field value, text start anywhere
                repeat ($urandom_range(1, 4))
                    send_cp(($urandom_range(0, 15) == 0), 4'($urandom_range(0, 15)),
                            1'($urandom_range(0, 1)), t_incb'($urandom_range(0, 3)));
            end
        endcase
    endtask

    // Output side: random stalls, plus one long hold-off to back up the block
    initial begin
        int  stall_left;
        bit  held_off;
        stall_left = 0;
        held_off   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata[0]);
                starts_seen++;
            end
            if (!held_off && starts_seen >= HOLD_AFTER) begin
                held_off = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (no_idle || $urandom_range(0, 99) < 70) begin
                m_axis_tready <= 1'b1;
            end else begin
                stall_left = idle_len() - 1;
                m_axis_tready <= 1'b0;
            end
        end
    end

    // Reset, directed run, random run, drain
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Start of text, CR LF pair, breaks after LF and control
        send_cp(1'b1, CLS_OTHER, 1'b0, INCB_NONE);
        send_cp(1'b0, CLS_CR, 1'b0, INCB_NONE);
        send_cp(1'b0, CLS_LF, 1'b0, INCB_NONE);
        send_cp(1'b0, CLS_LF, 1'b0, INCB_NONE);
        send_cp(1'b0, CLS_CONTROL, 1'b0, INCB_NONE);
        // Prepend and marks
        send_cp(1'b0, CLS_PREPEND, 1'b0, INCB_NONE);
        send_cp(1'b0, CLS_OTHER, 1'b0, INCB_NONE);
        send_cp(1'b0, CLS_SPACINGMARK, 1'b0, INCB_NONE);
        send_cp(1'b0, CLS_EXTEND, 1'b0, INCB_NONE);
        // Hangul jamo sequences
        send_cp(1'b0, CLS_L, 1'b0, INCB_NONE);
        send_cp(1'b0, CLS_V, 1'b0, INCB_NONE);
        send_cp(1'b0, CLS_T, 1'b0, INCB_NONE);
        send_cp(1'b0, CLS_LV, 1'b0, INCB_NONE);
        send_cp(1'b0, CLS_LVT, 1'b0, INCB_NONE);
        send_cp(1'b0, CLS_T, 1'b0, INCB_NONE);
        // Emoji ZWJ sequence
        send_cp(1'b0, CLS_OTHER, 1'b1, INCB_NONE);
        send_cp(1'b0, CLS_EXTEND, 1'b0, INCB_EXTEND);
        send_cp(1'b0, CLS_ZWJ, 1'b0, INCB_EXTEND);
        send_cp(1'b0, CLS_OTHER, 1'b1, INCB_NONE);
        // Regional indicator triple: pair joins, third breaks
        send_cp(1'b0, CLS_RI, 1'b0, INCB_NONE);
        send_cp(1'b0, CLS_RI, 1'b0, INCB_NONE);
        send_cp(1'b0, CLS_RI, 1'b0, INCB_NONE);
        // Conjunct across a linker
        send_cp(1'b0, CLS_OTHER, 1'b0, INCB_CONSONANT);
        send_cp(1'b0, CLS_EXTEND, 1'b0, INCB_LINKER);
        send_cp(1'b0, CLS_OTHER, 1'b0, INCB_CONSONANT);
        // Unused break classes, with a start of text in between
        send_cp(1'b0, 4'd14, 1'b1, INCB_LINKER);
        send_cp(1'b1, 4'd15, 1'b0, INCB_EXTEND);

        while (cp_sent < RANDOM_ITEMS) send_random_cluster();
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

### grapheme_boundary_detector.f
hdl/gbd_pkg.sv
hdl/gbd_front.sv
hdl/gbd_queue.sv
hdl/gbd_back.sv
hdl/grapheme_boundary_detector.sv
verif/tb.sv
